/* sv/rrtss_pkg.sv */
// rrtss_pkg: request codes and transfer payload types for the round robin
// task slot scheduler. No dependencies.
`default_nettype none

package rrtss_pkg;

    // request codes
    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_YIELD   = 2'd1;
    localparam logic [1:0] REQ_DESTROY = 2'd2;

    // fixed field widths
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SLOT_W = 4;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] entry_address;
        logic [ADDR_W-1:0] stack_address;
        logic [SLOT_W-1:0] target_slot;
    } req_item_t;

    typedef struct packed {
        logic              create_ok;
        logic [SLOT_W-1:0] created_slot;
        logic              current_valid;
        logic [SLOT_W-1:0] current_slot;
        logic [ADDR_W-1:0] current_entry;
        logic [ADDR_W-1:0] current_stack;
    } rsp_item_t;

endpackage

`default_nettype wire

/* sv/rrtss_ram.sv */
// rrtss_ram: generic single write port, single read port RAM with registered
// read data. Standalone, no package dependency.
`default_nettype none

module rrtss_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/round_robin_task_slot_scheduler_core.sv */
// Round robin task slot scheduler: slot table, scan sequencer and output register.
// Create and yield probe one slot per cycle, then read the RAM, then load the output
// register, waiting while it is held; destroy of a slot that is not current and
// unknown requests skip the probing. One item at a time; the length of the slot scan
// over the used marks decides how long a request takes. Reset clears all used marks and
// the current task at once; no clearing pass. Uses rrtss_pkg and rrtss_ram.
`default_nettype none

module round_robin_task_slot_scheduler_core
    import rrtss_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire req_item_t req_data,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp_data
);

    localparam int unsigned IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_FIND_FREE = 3'd1;
    localparam logic [2:0] ST_FIND_USED = 3'd2;
    localparam logic [2:0] ST_READ      = 3'd3;
    localparam logic [2:0] ST_RESP      = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic                  has_reg, has_next;
    logic [IW-1:0]         probe_reg, probe_next;
    logic [IW-1:0]         count_reg, count_next;
    logic                  ok_reg, ok_next;
    logic [IW-1:0]         made_reg, made_next;
    logic [ADDR_W-1:0]     entry_reg, stack_reg;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_item_t             rsp_data_reg, rsp_data_next;

    logic                  req_fire;
    logic                  probe_used;
    logic [IW-1:0]         probe_inc;
    logic [IW-1:0]         cur_inc;
    logic [IW-1:0]         target_idx;
    logic                  target_in_range;
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [2*ADDR_W-1:0]   ram_rd_data;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;

    // wrapping increments for the round robin probe
    assign probe_inc  = (probe_reg == LAST_SLOT) ? '0 : probe_reg + IW'(1);
    assign cur_inc    = (cur_reg == LAST_SLOT) ? '0 : cur_reg + IW'(1);
    assign probe_used = used_reg[probe_reg];

    assign target_idx      = IW'(req_data.target_slot);
    assign target_in_range = (32'(req_data.target_slot) < 32'(SLOT_COUNT));

    // sequencer and slot bookkeeping
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        cur_next       = cur_reg;
        has_next       = has_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        ok_next        = ok_reg;
        made_next      = made_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;

        // result leaves on transfer
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    ok_next    = 1'b0;
                    made_next  = '0;
                    count_next = '0;
                    state_next = ST_READ;
                    case (req_data.req_type)
                        REQ_CREATE:
                        begin
                            probe_next = '0;
                            state_next = ST_FIND_FREE;
                        end
                        REQ_YIELD:
                        begin
                            probe_next = cur_inc;
                            state_next = ST_FIND_USED;
                        end
                        REQ_DESTROY:
                        begin
                            // stored entry and stack need no clearing: only used slots are read
                            if (target_in_range)
                            begin
                                used_next[target_idx] = 1'b0;
                                if (has_reg && (cur_reg == target_idx))
                                begin
                                    probe_next = cur_inc;
                                    state_next = ST_FIND_USED;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_FIND_FREE:
            begin
                // lowest free slot, one probe per cycle
                if (!probe_used)
                begin
                    used_next[probe_reg] = 1'b1;
                    ram_wr_en            = 1'b1;
                    ok_next              = 1'b1;
                    made_next            = probe_reg;
                    if (!has_reg)
                    begin
                        cur_next = probe_reg;
                        has_next = 1'b1;
                    end
                    state_next = ST_READ;
                end
                else if (count_reg == LAST_SLOT)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    probe_next = probe_inc;
                    count_next = count_reg + IW'(1);
                end
            end
            ST_FIND_USED:
            begin
                // next used slot after the current one, current checked last
                if (probe_used)
                begin
                    cur_next   = probe_reg;
                    has_next   = 1'b1;
                    state_next = ST_READ;
                end
                else if (count_reg == LAST_SLOT)
                begin
                    has_next   = 1'b0;
                    state_next = ST_READ;
                end
                else
                begin
                    probe_next = probe_inc;
                    count_next = count_reg + IW'(1);
                end
            end
            ST_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // load the output register once it is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_data_next.create_ok    = ok_reg;
                    rsp_data_next.created_slot = SLOT_W'(made_reg);
                    rsp_data_next.current_valid = has_reg;
                    if (has_reg)
                    begin
                        rsp_data_next.current_slot  = SLOT_W'(cur_reg);
                        rsp_data_next.current_entry = ram_rd_data[2*ADDR_W-1:ADDR_W];
                        rsp_data_next.current_stack = ram_rd_data[ADDR_W-1:0];
                    end
                    else
                    begin
                        rsp_data_next.current_slot  = '0;
                        rsp_data_next.current_entry = '0;
                        rsp_data_next.current_stack = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            cur_reg       <= '0;
            has_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cur_reg       <= cur_next;
            has_reg       <= has_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        probe_reg    <= probe_next;
        count_reg    <= count_next;
        ok_reg       <= ok_next;
        made_reg     <= made_next;
        rsp_data_reg <= rsp_data_next;
        if (req_fire)
        begin
            entry_reg <= req_data.entry_address;
            stack_reg <= req_data.stack_address;
        end
    end

    // entry and stack table
    rrtss_ram #(
        .WIDTH (2 * ADDR_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (probe_reg),
        .wr_data ({entry_reg, stack_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (cur_reg),
        .rd_data (ram_rd_data)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire
